>>> rtl/chs_pkg.sv
// Shared types, constants, microcode and angle table for the compass heading smoother.
`timescale 1ns / 1ps

package chs_pkg;

  localparam int CORDIC_STEPS        = 16;
  localparam int ANGLE_FRACTION_BITS = 7;
  localparam int INT_FRAC            = 24;
  localparam int TABLE_LEN           = 24;
  localparam int STEP_W              = $clog2(TABLE_LEN);
  localparam int ATAN_W              = 30;
  localparam int XY_W                = 36;
  localparam int Z_W                 = 33;
  localparam int H_W                 = 34;
  localparam int SAMPLE_W            = 16;
  localparam int HEADING_W           = 16;
  localparam int WEIGHT_W            = 9;
  localparam int WEIGHT_ONE          = 256;
  localparam int WEIGHT_RESET        = 26;
  localparam int ACC_W               = 25;
  localparam int AVG_SHIFT           = 8;
  localparam int RND_SH              = INT_FRAC - ANGLE_FRACTION_BITS;
  localparam int Q_W                 = H_W - RND_SH;
  localparam int FULL_TURN           = 360 << ANGLE_FRACTION_BITS;
  localparam int PC_W                = 3;

  localparam logic [PC_W-1:0] PC_INIT    = 3'd0;
  localparam logic [PC_W-1:0] PC_ROT     = 3'd1;
  localparam logic [PC_W-1:0] PC_FOLD    = 3'd2;
  localparam logic [PC_W-1:0] PC_ROUND   = 3'd3;
  localparam logic [PC_W-1:0] PC_MUL_OLD = 3'd4;
  localparam logic [PC_W-1:0] PC_MUL_NEW = 3'd5;
  localparam logic [PC_W-1:0] PC_DONE    = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_ROT,
    OP_FOLD,
    OP_ROUND,
    OP_MUL_OLD,
    OP_MUL_NEW,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ZERO,
    COND_LOOP,
    COND_END
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic loop_more;
    logic out_free;
  } stat_t;

  localparam ctrl_t CTRL_IDLE = '{op: OP_NOP, cond: COND_NEXT, target: PC_INIT};

  // Control store: zero vectors skip the rotation, fold and rounding steps.
  function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      PC_INIT:    w = '{op: OP_INIT,    cond: COND_ZERO, target: PC_MUL_OLD};
      PC_ROT:     w = '{op: OP_ROT,     cond: COND_LOOP, target: PC_ROT};
      PC_FOLD:    w = '{op: OP_FOLD,    cond: COND_NEXT, target: PC_INIT};
      PC_ROUND:   w = '{op: OP_ROUND,   cond: COND_NEXT, target: PC_INIT};
      PC_MUL_OLD: w = '{op: OP_MUL_OLD, cond: COND_NEXT, target: PC_INIT};
      PC_MUL_NEW: w = '{op: OP_MUL_NEW, cond: COND_NEXT, target: PC_INIT};
      PC_DONE:    w = '{op: OP_DONE,    cond: COND_END,  target: PC_INIT};
      default:    w = '{op: OP_DONE,    cond: COND_END,  target: PC_INIT};
    endcase
    return w;
  endfunction

  // atan(2^-i) in degrees, scaled by 2^24
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/chs_sequencer.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps.
`timescale 1ns / 1ps

module chs_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  chs_pkg::stat_t  status,
  output logic            in_ready,
  output chs_pkg::ctrl_t  ctrl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                       state, state_next;
  logic [chs_pkg::PC_W-1:0]     pc, pc_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctrl = (state == S_RUN) ? chs_pkg::ucode_word(pc) : chs_pkg::CTRL_IDLE;
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RUN;
          pc_next    = chs_pkg::PC_INIT;
        end
      end
      S_RUN: begin
        unique case (ctrl.cond)
          chs_pkg::COND_NEXT: pc_next = pc + 1'b1;
          chs_pkg::COND_ZERO: pc_next = status.zero ? ctrl.target : pc + 1'b1;
          chs_pkg::COND_LOOP: pc_next = status.loop_more ? ctrl.target : pc + 1'b1;
          chs_pkg::COND_END: begin
            // hold on the last step until the output register frees up
            if (status.out_free) begin
              state_next = S_IDLE;
            end
          end
          default: pc_next = pc;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= chs_pkg::PC_INIT;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

>>> rtl/chs_datapath.sv
// Datapath: CORDIC vectoring unit, quadrant fold, rounding, averaging multiplier, output register.
`timescale 1ns / 1ps

module chs_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  chs_pkg::ctrl_t                         ctrl,
  input  logic                                   accept,
  input  logic signed [chs_pkg::SAMPLE_W-1:0]    field_x,
  input  logic signed [chs_pkg::SAMPLE_W-1:0]    field_y,
  input  logic                                   overflow,
  input  logic [chs_pkg::WEIGHT_W-1:0]           weight,
  input  logic                                   out_ready,
  output chs_pkg::stat_t                         status,
  output logic                                   out_valid,
  output logic [chs_pkg::HEADING_W-1:0]          raw_heading,
  output logic [chs_pkg::HEADING_W-1:0]          smoothed_heading
);

  localparam logic [chs_pkg::Z_W-2:0] Z90  = 32'(90 << chs_pkg::INT_FRAC);
  localparam logic [chs_pkg::H_W-1:0] H180 = chs_pkg::H_W'(64'd180 << chs_pkg::INT_FRAC);
  localparam logic [chs_pkg::H_W-1:0] H360 = chs_pkg::H_W'(64'd360 << chs_pkg::INT_FRAC);
  localparam logic [chs_pkg::H_W-1:0] H_HALF = chs_pkg::H_W'(64'd1 << (chs_pkg::RND_SH - 1));
  localparam logic [chs_pkg::Q_W-1:0] Q_FULL = chs_pkg::Q_W'(chs_pkg::FULL_TURN);
  localparam logic [chs_pkg::WEIGHT_W-1:0] W_ONE = chs_pkg::WEIGHT_W'(chs_pkg::WEIGHT_ONE);
  localparam logic [chs_pkg::ACC_W-1:0] ACC_HALF =
    chs_pkg::ACC_W'(1 << (chs_pkg::AVG_SHIFT - 1));

  // captured sample
  logic signed [chs_pkg::SAMPLE_W-1:0] sx, sy;
  logic                                zero;

  // CORDIC state
  logic signed [chs_pkg::XY_W-1:0]  xr, yr;
  logic signed [chs_pkg::Z_W-1:0]   zr;
  logic [chs_pkg::STEP_W-1:0]       it;

  logic [chs_pkg::H_W-1:0]          hr;
  logic [chs_pkg::HEADING_W-1:0]    raw;
  logic [chs_pkg::ACC_W-1:0]        acc;
  logic [chs_pkg::HEADING_W-1:0]    avg;

  logic [chs_pkg::SAMPLE_W:0]       ax, ay;
  logic signed [chs_pkg::XY_W-1:0]  dx, dy;
  logic signed [chs_pkg::Z_W-1:0]   dz;
  logic [chs_pkg::Z_W-2:0]          a_clamp;
  logic [chs_pkg::H_W-1:0]          a_ext, h_val;
  logic [chs_pkg::H_W-1:0]          h_rnd;
  logic [chs_pkg::Q_W-1:0]          q;
  logic [chs_pkg::WEIGHT_W-1:0]     w_sat, w_old;
  logic [chs_pkg::HEADING_W-1:0]    mul_a;
  logic [chs_pkg::WEIGHT_W-1:0]     mul_b;
  logic [chs_pkg::ACC_W-1:0]        prod;
  logic                             out_free;

  assign out_free         = !out_valid || out_ready;
  assign status.zero      = zero;
  assign status.loop_more = (it != chs_pkg::STEP_W'(chs_pkg::CORDIC_STEPS - 1));
  assign status.out_free  = out_free;

  always_comb begin
    ax = sx[chs_pkg::SAMPLE_W-1] ? (17'd0 - {sx[chs_pkg::SAMPLE_W-1], sx})
                                 : {sx[chs_pkg::SAMPLE_W-1], sx};
    ay = sy[chs_pkg::SAMPLE_W-1] ? (17'd0 - {sy[chs_pkg::SAMPLE_W-1], sy})
                                 : {sy[chs_pkg::SAMPLE_W-1], sy};
    dx = yr >>> it;
    dy = xr >>> it;
    dz = signed'({3'b000, chs_pkg::atan_deg(it)});
  end

  // clamp to [0, 90] degrees, then place in the quadrant
  always_comb begin
    if (zr[chs_pkg::Z_W-1]) begin
      a_clamp = '0;
    end else if (zr[chs_pkg::Z_W-2:0] > Z90) begin
      a_clamp = Z90;
    end else begin
      a_clamp = zr[chs_pkg::Z_W-2:0];
    end
    a_ext = {2'b00, a_clamp};
    priority if (!sx[chs_pkg::SAMPLE_W-1] && !sy[chs_pkg::SAMPLE_W-1]) begin
      h_val = a_ext;
    end else if (sx[chs_pkg::SAMPLE_W-1] && !sy[chs_pkg::SAMPLE_W-1]) begin
      h_val = H180 - a_ext;
    end else if (sx[chs_pkg::SAMPLE_W-1]) begin
      h_val = H180 + a_ext;
    end else begin
      h_val = H360 - a_ext;
    end
  end

  always_comb begin
    h_rnd = hr + H_HALF;
    q     = h_rnd[chs_pkg::H_W-1:chs_pkg::RND_SH];
    if (q >= Q_FULL) begin
      q = q - Q_FULL;
    end
  end

  // one multiplier shared by both terms of the average
  always_comb begin
    w_sat = (weight > W_ONE) ? W_ONE : weight;
    w_old = W_ONE - w_sat;
    if (ctrl.op == chs_pkg::OP_MUL_OLD) begin
      mul_a = avg;
      mul_b = w_old;
    end else begin
      mul_a = raw;
      mul_b = w_sat;
    end
    prod = chs_pkg::ACC_W'(mul_a * mul_b);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx   <= field_x;
      sy   <= field_y;
      zero <= overflow || (field_x == '0 && field_y == '0);
    end
    unique case (ctrl.op)
      chs_pkg::OP_INIT: begin
        xr <= signed'({3'b000, ax, 16'h0000});
        yr <= signed'({3'b000, ay, 16'h0000});
        zr <= '0;
        it <= '0;
        if (zero) begin
          raw <= '0;
        end
      end
      chs_pkg::OP_ROT: begin
        if (!yr[chs_pkg::XY_W-1]) begin
          xr <= xr + dx;
          yr <= yr - dy;
          zr <= zr + dz;
        end else begin
          xr <= xr - dx;
          yr <= yr + dy;
          zr <= zr - dz;
        end
        it <= it + 1'b1;
      end
      chs_pkg::OP_FOLD:    hr  <= h_val;
      chs_pkg::OP_ROUND:   raw <= chs_pkg::HEADING_W'(q);
      chs_pkg::OP_MUL_OLD: acc <= prod + ACC_HALF;
      chs_pkg::OP_MUL_NEW: acc <= acc + prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      avg       <= '0;
    end else begin
      if (ctrl.op == chs_pkg::OP_DONE && out_free) begin
        out_valid        <= 1'b1;
        avg              <= acc[chs_pkg::AVG_SHIFT +: chs_pkg::HEADING_W];
        raw_heading      <= raw;
        smoothed_heading <= acc[chs_pkg::AVG_SHIFT +: chs_pkg::HEADING_W];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/compass_heading_smoother.sv
// Zero or overflowed samples skip the CORDIC, fold and rounding steps.
// One request at a time, through a 16-step iterative CORDIC loop; the next is taken once idle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): weight to 26, average to 0, sequencer idle, no result.
// Top level: weight register, microcode sequencer and datapath.
`timescale 1ns / 1ps

module compass_heading_smoother (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [chs_pkg::WEIGHT_W-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [chs_pkg::SAMPLE_W-1:0]   field_x,
  input  logic signed [chs_pkg::SAMPLE_W-1:0]   field_y,
  input  logic                                  overflow,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [chs_pkg::HEADING_W-1:0]         raw_heading,
  output logic [chs_pkg::HEADING_W-1:0]         smoothed_heading
);

  logic [chs_pkg::WEIGHT_W-1:0] weight;
  chs_pkg::ctrl_t               ctrl;
  chs_pkg::stat_t               status;
  logic                         accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= chs_pkg::WEIGHT_W'(chs_pkg::WEIGHT_RESET);
    end else if (cfg_wr_en) begin
      weight <= cfg_wr_data;
    end
  end

  chs_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  chs_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .accept           (accept),
    .field_x          (field_x),
    .field_y          (field_y),
    .overflow         (overflow),
    .weight           (weight),
    .out_ready        (out_ready),
    .status           (status),
    .out_valid        (out_valid),
    .raw_heading      (raw_heading),
    .smoothed_heading (smoothed_heading)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer took a request but stayed idle");

  a_raw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> raw_heading < 16'(chs_pkg::FULL_TURN))
    else $error("raw heading outside [0,360)");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> smoothed_heading < 16'(chs_pkg::FULL_TURN))
    else $error("smoothed heading outside [0,360)");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in progress");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for compass_heading_smoother: directed and randomized samples, bit-exact heading prediction.
`timescale 1ns / 1ps

module tb_top;

  localparam int   STEPS       = 16;
  localparam int   FRAC_OUT    = 7;
  localparam int   TURN        = 360 << FRAC_OUT;
  localparam int   QUIET_LIMIT = 4000;
  localparam int   SETTLE      = 30;
  localparam longint ONE_DEG   = longint'(1) << 24;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_LUT [16] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  typedef struct {
    logic signed [chs_pkg::SAMPLE_W-1:0] x;
    logic signed [chs_pkg::SAMPLE_W-1:0] y;
    logic                                ovf;
  } sample_t;

  typedef struct {
    logic [chs_pkg::HEADING_W-1:0] raw;
    logic [chs_pkg::HEADING_W-1:0] smooth;
  } heading_pair_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_wr_en = 1'b0;
  logic [chs_pkg::WEIGHT_W-1:0]        cfg_wr_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [chs_pkg::SAMPLE_W-1:0] field_x = '0;
  logic signed [chs_pkg::SAMPLE_W-1:0] field_y = '0;
  logic                                overflow = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [chs_pkg::HEADING_W-1:0]       raw_heading;
  logic [chs_pkg::HEADING_W-1:0]       smoothed_heading;

  sample_t       sample_queue[$];
  heading_pair_t heading_queue[$];
  heading_pair_t got_pair;
  longint        avg_model = 0;
  int            weight_model = chs_pkg::WEIGHT_RESET;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            recv_stall = 0;
  int            errors = 0;
  int            quiet_cycles = 0;

  compass_heading_smoother DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .field_x          (field_x),
    .field_y          (field_y),
    .overflow         (overflow),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .raw_heading      (raw_heading),
    .smoothed_heading (smoothed_heading)
  );

  always #4 clk = ~clk;

  // Vectoring CORDIC on the first-quadrant magnitudes, then quadrant fold and rounding.
  function automatic logic [chs_pkg::HEADING_W-1:0] heading_of(
      input logic signed [chs_pkg::SAMPLE_W-1:0] sx,
      input logic signed [chs_pkg::SAMPLE_W-1:0] sy);
    longint ax, ay, x, y, z, dx, dy, h, q;
    if (sx == 0 && sy == 0) return '0;
    ax = (sx < 0) ? -longint'(sx) : longint'(sx);
    ay = (sy < 0) ? -longint'(sy) : longint'(sy);
    x = ax <<< 16;
    y = ay <<< 16;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_LUT[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_LUT[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * ONE_DEG) z = 90 * ONE_DEG;
    if (sx >= 0 && sy >= 0) h = z;
    else if (sx < 0 && sy >= 0) h = 180 * ONE_DEG - z;
    else if (sx < 0) h = 180 * ONE_DEG + z;
    else h = 360 * ONE_DEG - z;
    q = (h + (longint'(1) <<< 16)) >>> 17;
    if (q >= TURN) q = q - TURN;   // rounding up to 360 folds to 0
    return q[chs_pkg::HEADING_W-1:0];
  endfunction

  function automatic void queue_sample(input int x, input int y, input bit ovf);
    sample_t s;
    s.x = chs_pkg::SAMPLE_W'(x);
    s.y = chs_pkg::SAMPLE_W'(y);
    s.ovf = ovf;
    sample_queue.push_back(s);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(99);
    s.x = chs_pkg::SAMPLE_W'($urandom);
    s.y = chs_pkg::SAMPLE_W'($urandom);
    s.ovf = 1'b0;
    if (pick < 10) begin
      s.x = chs_pkg::SAMPLE_W'($urandom_range(8) - 4);
      s.y = chs_pkg::SAMPLE_W'($urandom_range(8) - 4);
    end else if (pick < 18) begin
      s.y = chs_pkg::SAMPLE_W'($urandom_range(6) - 3);
    end else if (pick < 25) begin
      s.x = chs_pkg::SAMPLE_W'($urandom_range(6) - 3);
    end else if (pick < 35) begin
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  task automatic push_random(input int n);
    repeat (n) sample_queue.push_back(random_sample());
  endtask

  task automatic write_weight(input logic [chs_pkg::WEIGHT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weight_model = int'(v);
    @(negedge clk);
  endtask

  // Wait until every request went in and every result came out, then let the block settle.
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || heading_queue.size() != 0 || recv_stall > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Driver: predicts on acceptance, then offers the next pending sample.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        heading_pair_t p;
        int w;
        p.raw = overflow ? '0 : heading_of(field_x, field_y);
        w = (weight_model > chs_pkg::WEIGHT_ONE) ? chs_pkg::WEIGHT_ONE : weight_model;
        avg_model = (avg_model * (chs_pkg::WEIGHT_ONE - w) + longint'(p.raw) * w + 128)
                    >>> chs_pkg::AVG_SHIFT;
        avg_model = avg_model & 16'hFFFF;
        p.smooth = avg_model[chs_pkg::HEADING_W-1:0];
        heading_queue.push_back(p);
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = sample_queue.pop_front();
          field_x  <= s.x;
          field_y  <= s.y;
          overflow <= s.ovf;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (heading_queue.size() == 0) begin
          $error("unexpected result: raw_heading=%0d smoothed_heading=%0d",
                 raw_heading, smoothed_heading);
          errors++;
        end else begin
          got_pair = heading_queue.pop_front();
          if (raw_heading !== got_pair.raw) begin
            $error("raw_heading: expected %0d, got %0d", got_pair.raw, raw_heading);
            errors++;
          end
          if (smoothed_heading !== got_pair.smooth) begin
            $error("smoothed_heading: expected %0d, got %0d", got_pair.smooth, smoothed_heading);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any request or result moving.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed samples under the reset weight
    send_idle_pct = 37;
    recv_idle_pct = 85;
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 1);
    queue_sample(12345, -4321, 1);
    queue_sample(-32768, -32768, 1);
    queue_sample(32767, 0, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 32767, 0);
    queue_sample(0, -32768, 0);
    queue_sample(32767, 32767, 0);
    queue_sample(-32768, -32768, 0);
    queue_sample(-32768, 32767, 0);
    queue_sample(32767, -32768, 0);
    queue_sample(1, 0, 0);
    queue_sample(-1, 0, 0);
    queue_sample(0, 1, 0);
    queue_sample(0, -1, 0);
    queue_sample(1, 1, 0);
    queue_sample(-1, -1, 0);
    queue_sample(32767, -1, 0);   // just below 360, rounds to a full turn
    queue_sample(-32768, -1, 0);
    queue_sample(-1, 32767, 0);
    queue_sample(1, -32768, 0);
    drain();

    write_weight(9'd256);
    push_random(240);
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 37;
    write_weight(9'd0);
    push_random(240);
    drain();

    write_weight(9'd511);   // saturates to full weight
    push_random(240);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_weight(9'd1);
    push_random(240);
    recv_stall = 400;       // back up the block while the sender keeps offering
    drain();

    write_weight(chs_pkg::WEIGHT_W'($urandom_range(511)));
    push_random(120);
    drain();
    push_random(120);
    drain();

    write_weight(9'd128);
    push_random(240);
    drain();

    if (heading_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
